// ===== rtl/core/jfe_pkg.sv =====
// shared constants, codes and port structs of the jpeg frame extractor
package jfe_pkg;

  localparam int STORE_DEPTH = 32768;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 15;
  localparam int LEN_W       = 16;
  localparam int CNT_W       = 32;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 88;

  localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_SOI    = 8'hD8;
  localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;

  localparam logic [LEN_W-1:0] CAP_RESET     = 16'd32768;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd20;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_MIN_LEN  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_STREAM = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DONE = 2'd1,
    EV_DROP = 2'd2
  } frame_event_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

// ===== rtl/core/jfe_store.sv =====
// frame store: one write port, one read port with registered read data
module jfe_store (
  input  logic                        clk,
  input  jfe_pkg::store_wr_t          wr,
  input  jfe_pkg::store_rd_t          rd,
  output logic [jfe_pkg::BYTE_W-1:0]  rd_data
);
  import jfe_pkg::*;

  logic [BYTE_W-1:0] mem_r [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/jpeg_frame_extractor_core.sv =====
// jpeg frame extractor top level: marker tracking, frame store and result stages
//
//  channel  dir  payload
//  in_      in   tuser: operation; tdata: byte_value, read_index
//  out_     out  tuser: frame_event; tdata: read_data, frame_length, totals
//  cfg_     in   index 0 frame_capacity, index 1 min_frame_length
//
// one beat per cycle on both sides while out_tready stays high; each beat yields one result beat
// each result passes the store access stage, then the output register
// out_tready low holds both stages; in_tready drops once both hold a beat
// store read data is registered, so a read sees every earlier beat's write
// entry 0 always holds the start prefix byte and is not kept in the store
// reset is synchronous; the store itself is not cleared
module jpeg_frame_extractor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [jfe_pkg::IN_DATA_W-1:0]      in_tdata,   // byte_value, read_index, pad
  input  logic                               in_tuser,   // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [jfe_pkg::OUT_DATA_W-1:0]     out_tdata,  // read_data, frame_length, frames_total, dropped_total
  output logic [1:0]                         out_tuser,  // frame_event
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [jfe_pkg::LEN_W-1:0]          cfg_wdata
);
  import jfe_pkg::*;

  logic [LEN_W-1:0]  cap_r, min_len_r;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic              prev_v_r, prev_v_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  bad_r, bad_nxt;

  logic              s1_v_r, s1_read_r, s1_head_r, s1_hit_r;
  frame_event_t      s1_ev_r;
  logic [LEN_W-1:0]  s1_flen_r;
  logic [CNT_W-1:0]  s1_good_r, s1_bad_r;

  logic                  out_v_r;
  frame_event_t          out_ev_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              in_acc, adv, marker, in_range, idx_zero;
  op_t               op;
  logic [BYTE_W-1:0] in_byte;
  logic [IDX_W-1:0]  in_idx;
  logic [LEN_W-1:0]  cap_use, len_a, flen;
  logic              ovf_a;
  frame_event_t      ev;
  store_wr_t         wr;
  store_rd_t         rd;
  logic [BYTE_W-1:0] mem_q, s1_rdata;

  assign op       = op_t'(in_tuser);
  assign in_byte  = in_tdata[7:0];
  assign in_idx   = in_tdata[22:8];
  assign adv      = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign in_acc   = in_tvalid && in_tready;
  assign marker   = prev_v_r && (prev_r == MARK_PREFIX);
  assign in_range = (32'(in_idx) < 32'(STORE_DEPTH));
  assign idx_zero = (in_idx == '0);
  assign cap_use  = (32'(cap_r) < 32'(STORE_DEPTH)) ? cap_r : LEN_W'(STORE_DEPTH);

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r     <= cfg_wdata;
        CFG_MIN_LEN:  min_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // marker tracking and store writes
  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    prev_v_nxt   = prev_v_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    len_a        = len_r;
    ovf_a        = ovf_r;
    flen         = len_r;
    ev           = EV_NONE;
    wr           = '0;
    if (in_acc && (op == OP_STREAM)) begin
      if (!in_frame_r) begin
        if (marker && (in_byte == MARK_SOI)) begin
          in_frame_nxt = 1'b1;
          if (cap_use == '0) begin
            ovf_a = 1'b1;
            len_a = '0;
          end else if (cap_use == LEN_W'(1)) begin
            ovf_a = 1'b1;
            len_a = LEN_W'(1);
          end else begin
            ovf_a   = 1'b0;
            len_a   = LEN_W'(2);
            wr.en   = 1'b1;
            wr.addr = ADDR_W'(1);
            wr.data = MARK_SOI;
          end
        end
      end else if (!ovf_r) begin
        if (len_r >= cap_use) begin
          ovf_a = 1'b1;
        end else begin
          wr.en   = 1'b1;
          wr.addr = ADDR_W'(len_r);
          wr.data = in_byte;
          len_a   = len_r + LEN_W'(1);
        end
      end
      flen    = len_a;
      len_nxt = len_a;
      ovf_nxt = ovf_a;
      if (in_frame_r && marker && (in_byte == MARK_EOI)) begin
        in_frame_nxt = 1'b0;
        ovf_nxt      = 1'b0;
        len_nxt      = '0;
        if (ovf_a || (len_a < min_len_r)) begin
          bad_nxt = bad_r + CNT_W'(1);
          ev      = EV_DROP;
          flen    = '0;
        end else begin
          good_nxt = good_r + CNT_W'(1);
          ev       = EV_DONE;
        end
      end
      prev_nxt   = in_byte;
      prev_v_nxt = 1'b1;
    end
  end

  always_comb begin
    rd.en   = in_acc && (op == OP_READ) && in_range && !idx_zero;
    rd.addr = ADDR_W'(in_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= '0;
      prev_v_r   <= 1'b0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      good_r     <= '0;
      bad_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
      prev_v_r   <= prev_v_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
    end
  end

  jfe_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (mem_q)
  );

  // store access stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_read_r <= (op == OP_READ);
      s1_head_r <= idx_zero;
      s1_hit_r  <= in_range;
      s1_ev_r   <= ev;
      s1_flen_r <= flen;
      s1_good_r <= good_nxt;
      s1_bad_r  <= bad_nxt;
    end
  end

  always_comb begin
    s1_rdata = '0;
    if (s1_read_r && s1_hit_r) begin
      s1_rdata = s1_head_r ? MARK_PREFIX : mem_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_ev_r   <= s1_ev_r;
      out_data_r <= {s1_bad_r, s1_good_r, s1_flen_r, s1_rdata};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ev_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(STORE_DEPTH))
    else $error("stored length beyond store depth");

  a_idle_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> !ovf_r)
    else $error("overflow flag set while searching");

  a_no_head_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (wr.addr != '0) && (32'(wr.addr) < 32'(cap_use)))
    else $error("store write outside frame body");

  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (ev == EV_DROP)) |=> (bad_r == $past(bad_r) + CNT_W'(1)))
    else $error("dropped frame not counted");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_flen_r) && $stable(s1_rdata)))
    else $error("stalled access stage lost its beat");
`endif

endmodule

// ===== verif/jpeg_frame_extractor_core_tb.sv =====
// self-checking testbench of the jpeg frame extractor core with a scoreboard class
module jpeg_frame_extractor_core_tb;
  import jfe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    frame_event_t      ev;
    logic [LEN_W-1:0]  frame_length;
    logic [CNT_W-1:0]  frames_total;
    logic [CNT_W-1:0]  dropped_total;
  } frame_result_t;

  class frame_scoreboard;
    logic [LEN_W-1:0]  capacity;
    logic [LEN_W-1:0]  min_len;
    bit                in_frame;
    bit                prev_valid;
    bit                overflowed;
    logic [BYTE_W-1:0] prev_byte;
    int unsigned       stored_len;
    int unsigned       written_hi;
    logic [CNT_W-1:0]  good_cnt;
    logic [CNT_W-1:0]  bad_cnt;
    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    frame_result_t     pending[$];
    int                errors;

    function new();
      capacity   = CAP_RESET;
      min_len    = MIN_LEN_RESET;
      in_frame   = 0;
      prev_valid = 0;
      overflowed = 0;
      prev_byte  = '0;
      stored_len = 0;
      written_hi = 0;
      good_cnt   = '0;
      bad_cnt    = '0;
      errors     = 0;
    endfunction

    function void set_config(cfg_index_t idx, logic [LEN_W-1:0] val);
      if (idx == CFG_CAPACITY) capacity = val;
      else min_len = val;
    endfunction

    function void put_byte(logic [BYTE_W-1:0] v);
      int unsigned cap;
      cap = (capacity < STORE_DEPTH) ? capacity : STORE_DEPTH;
      if (overflowed) return;
      if (stored_len >= cap) begin
        overflowed = 1;
        return;
      end
      store_mem[stored_len] = v;
      stored_len++;
      if (stored_len > written_hi) written_hi = stored_len;
    endfunction

    function void note_beat(op_t op, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
      frame_result_t r;
      bit            marker;
      r    = '0;
      r.ev = EV_NONE;
      if (op == OP_READ) begin
        if (idx < STORE_DEPTH) r.read_data = store_mem[idx];
        r.frame_length = stored_len[LEN_W-1:0];
      end else begin
        marker = prev_valid && prev_byte == MARK_PREFIX;
        if (!in_frame) begin
          if (marker && b == MARK_SOI) begin
            in_frame   = 1;
            stored_len = 0;
            overflowed = 0;
            put_byte(MARK_PREFIX);
            put_byte(MARK_SOI);
          end
        end else begin
          put_byte(b);
          if (marker && b == MARK_EOI) begin
            if (overflowed || stored_len < min_len) begin
              bad_cnt++;
              r.ev = EV_DROP;
            end else begin
              good_cnt++;
              r.ev = EV_DONE;
            end
            in_frame   = 0;
            overflowed = 0;
          end
        end
        r.frame_length = stored_len[LEN_W-1:0];
        if (r.ev != EV_NONE) stored_len = 0;
        if (r.ev == EV_DROP) r.frame_length = '0;
        prev_byte  = b;
        prev_valid = 1;
      end
      r.frames_total  = good_cnt;
      r.dropped_total = bad_cnt;
      pending.push_back(r);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data, logic [1:0] ev);
      frame_result_t e;
      frame_result_t a;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, data %h event %0d", $time, data, ev);
        return;
      end
      e               = pending.pop_front();
      a.read_data     = data[7:0];
      a.frame_length  = data[23:8];
      a.frames_total  = data[55:24];
      a.dropped_total = data[87:56];
      a.ev            = frame_event_t'(ev);
      if (a.read_data !== e.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, a.read_data);
      end
      if (a.ev !== e.ev) begin
        errors++;
        $display("%0t: frame_event expected %0d actual %0d", $time, e.ev, ev);
      end
      if (a.frame_length !== e.frame_length) begin
        errors++;
        $display("%0t: frame_length expected %0d actual %0d", $time, e.frame_length,
                 a.frame_length);
      end
      if (a.frames_total !== e.frames_total) begin
        errors++;
        $display("%0t: frames_total expected %0d actual %0d", $time, e.frames_total,
                 a.frames_total);
      end
      if (a.dropped_total !== e.dropped_total) begin
        errors++;
        $display("%0t: dropped_total expected %0d actual %0d", $time, e.dropped_total,
                 a.dropped_total);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // byte_value, read_index, pad
  logic                  in_tuser   = 1'b0; // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // read_data, frame_length, frames_total, dropped_total
  logic [1:0]            out_tuser;         // frame_event
  logic                  cfg_we     = 1'b0;
  logic [0:0]            cfg_index  = '0;
  logic [LEN_W-1:0]      cfg_wdata  = '0;

  frame_scoreboard sb = new();
  int burst_left = 0;
  int gap_left   = 0;
  int sent_beats = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;

  jpeg_frame_extractor_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cyc++;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_beat(op_t'(in_tuser), in_tdata[7:0], in_tdata[22:8]);
      if (out_tvalid && out_tready)
        sb.check_beat(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver stall pattern, switching at random between four modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom % 4) != 0;
      2: out_tready <= (cyc % 5) != 0;
      default: out_tready <= 1'($urandom % 2);
    endcase
  end

  task automatic drive_beat(input op_t op, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap_left   = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, idx, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent_beats++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    drive_beat(OP_STREAM, b, IDX_W'($urandom));
  endtask

  task automatic send_read(input int unsigned idx);
    drive_beat(OP_READ, BYTE_W'($urandom), idx[IDX_W-1:0]);
  endtask

  // read somewhere inside what has been written so far
  task automatic send_random_read();
    int unsigned hi;
    hi = sb.written_hi;
    if (hi == 0) return;
    case ($urandom % 4)
      0: send_read(hi - 1);
      1: send_read(0);
      default: send_read($urandom_range(0, hi - 1));
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [LEN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_config(idx, val);
  endtask

  task automatic configure(input logic [LEN_W-1:0] cap, input logic [LEN_W-1:0] min_len);
    drain();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_MIN_LEN, min_len);
    cfg_we <= 1'b0;
  endtask

  // start marker, body without an end pair, end marker, reads mixed in
  task automatic send_frame(input int body_len, input int read_pct);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] last;
    send_byte(MARK_PREFIX);
    send_byte(MARK_SOI);
    last = MARK_SOI;
    for (int i = 0; i < body_len; i++) begin
      b = ($urandom % 8 == 0) ? MARK_PREFIX : BYTE_W'($urandom);
      if (last == MARK_PREFIX && b == MARK_EOI) b = MARK_SOI;
      send_byte(b);
      last = b;
      if ($urandom_range(0, 99) < read_pct) send_random_read();
    end
    send_byte(MARK_PREFIX);
    if ($urandom_range(0, 99) < read_pct) send_random_read();
    send_byte(MARK_EOI);
  endtask

  initial begin
    int unsigned hi;
    int          unit;
    int          phase_end;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] mlen;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(CAP_RESET, MIN_LEN_RESET);

    // end pair while searching, markers split by a read, prefix repeats inside a frame
    send_byte(8'h00);
    send_byte(MARK_PREFIX);
    send_byte(MARK_EOI);
    send_byte(MARK_PREFIX);
    send_byte(MARK_SOI);
    send_byte(8'h00);
    send_byte(MARK_PREFIX);
    send_byte(MARK_PREFIX);
    send_byte(MARK_SOI);
    send_read(0);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(MARK_PREFIX);
    send_read(1);
    send_byte(MARK_EOI);
    send_read(9);
    send_frame(16, 0);
    send_frame(15, 0);

    configure(16'd4, 16'd0);
    send_frame(0, 0);
    send_frame(3, 0);
    for (int i = 0; i < 4; i++) send_read(i);

    configure(16'd32768, 16'd32768);
    send_frame(1, 0);

    // one long frame so that higher store positions get written and read
    configure(16'd32768, 16'd20);
    send_frame(600, 0);
    hi = sb.written_hi;
    send_read(hi - 1);
    for (int i = 0; i < 12; i++) send_read($urandom_range(hi / 2, hi - 1));
    for (int i = 0; i < 12; i++) send_read($urandom_range(0, hi - 1));

    while (sent_beats < 1950) begin
      case ($urandom % 6)
        0: cap = 16'd4;
        1: cap = 16'd32768;
        2: cap = LEN_W'($urandom_range(4, 64));
        default: cap = LEN_W'($urandom_range(16, 200));
      endcase
      case ($urandom % 6)
        0: mlen = 16'd0;
        1: mlen = 16'd32768;
        2: mlen = 16'd20;
        default: mlen = LEN_W'($urandom_range(0, 60));
      endcase
      configure(cap, mlen);
      phase_end = sent_beats + $urandom_range(80, 250);
      while (sent_beats < phase_end) begin
        unit = $urandom_range(0, 99);
        if (unit < 70) begin
          repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom));
          send_frame(($urandom % 10 == 0) ? $urandom_range(50, 150) : $urandom_range(0, 40),
                     $urandom_range(0, 30));
        end else if (unit < 85) begin
          repeat ($urandom_range(1, 12)) begin
            if ($urandom % 5 == 0) send_random_read();
            else send_byte(($urandom % 3 == 0) ? MARK_PREFIX : BYTE_W'($urandom));
          end
        end else begin
          // broken sequences: frame with no end, restart inside a frame, stray end pair
          send_byte(MARK_PREFIX);
          send_byte(MARK_SOI);
          repeat ($urandom_range(0, 20)) send_byte(BYTE_W'($urandom));
          if ($urandom % 2) begin
            send_byte(MARK_PREFIX);
            send_byte(MARK_SOI);
          end
          if ($urandom % 2) send_random_read();
          if ($urandom % 2) begin
            send_byte(MARK_PREFIX);
            send_byte(MARK_EOI);
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
